@@ rtl/rar_pkg.sv @@
// Shared types and operation codes for the rational arithmetic core.
// No dependencies; imported by rar_addsub and the top level.
`timescale 1ns / 1ps

package rar_pkg;

  // Operand width of the shared add/subtract unit: a 33-bit signed raw
  // numerator plus one guard bit for the sign of a difference.
  localparam int WORD_W = 34;

  typedef logic signed [WORD_W-1:0] rar_word_t;
  typedef logic [1:0] rar_func_t;

  localparam rar_func_t FUNC_ADD = 2'd0;
  localparam rar_func_t FUNC_SUB = 2'd1;
  localparam rar_func_t FUNC_MUL = 2'd2;
  localparam rar_func_t FUNC_DIV = 2'd3;

endpackage

@@ rtl/rar_addsub.sv @@
// Shared add/subtract unit for the rational arithmetic core.
// Depends on rar_pkg for the operand type.
`timescale 1ns / 1ps

module rar_addsub (
  input  rar_pkg::rar_word_t a,
  input  rar_pkg::rar_word_t b,
  input  logic               sub,
  output rar_pkg::rar_word_t res
);
  import rar_pkg::*;

  assign res = sub ? (a - b) : (a + b);

endmodule

@@ rtl/rar_mul.sv @@
// Registered 16x16 signed multiplier, shared across the cross products.
// No package dependencies.
`timescale 1ns / 1ps

module rar_mul (
  input  logic               clk,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [31:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/rational_alu_with_reduction_core.sv @@
// Rational add/subtract/multiply/divide with reduction to lowest terms.
// An error or zero result goes straight from the zero checks to the output;
// any other result is reduced by the binary GCD loop and two 32-step
// restoring divisions, all on one shared adder.
// Throughput: one word at a time; in_ready is high only while idle.
// Reset (synchronous, active high) returns to idle and drops out_valid.
`timescale 1ns / 1ps

module rational_alu_with_reduction_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rar_pkg::rar_func_t  func,
  input  logic signed [15:0]  num_a,
  input  logic signed [15:0]  den_a,
  input  logic signed [15:0]  num_b,
  input  logic signed [15:0]  den_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [32:0]  num_out,
  output logic signed [31:0]  den_out,
  output logic                bad_denominator
);
  import rar_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;  // issue numerator product
  localparam logic [3:0] S_MUL1 = 4'd2;  // issue second cross product
  localparam logic [3:0] S_MUL2 = 4'd3;  // issue denominator product
  localparam logic [3:0] S_MUL3 = 4'd4;  // capture denominator product
  localparam logic [3:0] S_ADD  = 4'd5;  // combine cross products, or pass the numerator product
  localparam logic [3:0] S_CHK  = 4'd6;  // zero checks
  localparam logic [3:0] S_ABSN = 4'd7;
  localparam logic [3:0] S_ABSD = 4'd8;
  localparam logic [3:0] S_GCD  = 4'd9;
  localparam logic [3:0] S_DIVN = 4'd10;
  localparam logic [3:0] S_DIVD = 4'd11;
  localparam logic [3:0] S_NEGN = 4'd12;
  localparam logic [3:0] S_NEGD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;

  // Latched operands
  rar_func_t          fn;
  logic signed [15:0] na, da, nb, db;

  // Products and raw result
  logic signed [31:0] p0, p1, rd;
  logic signed [32:0] rn;
  logic               sign_n, sign_d;

  // GCD and division datapath
  logic [31:0] mag_n, mag_d;   // magnitudes; mag_n later holds the numerator quotient
  logic [31:0] u, v;
  logic [31:0] q;              // dividend shifting out, quotient shifting in
  logic [31:0] rem;
  logic [4:0]  cnt;

  // Result staging
  logic signed [32:0] res_num;
  logic signed [31:0] res_den;
  logic               res_bad;

  // Shared multiplier
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] mul_p;

  // Shared adder
  rar_word_t alu_a, alu_b, alu_res;
  logic      alu_sub;

  logic [31:0] div_trial_in;
  logic        div_bit;

  rar_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rar_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign in_ready = (state == S_IDLE);

  // Partial remainder with the next dividend bit shifted in; the remainder
  // stays below the odd divisor, so 31 bits carry it.
  assign div_trial_in = {rem[30:0], q[31]};
  assign div_bit      = ~alu_res[WORD_W-1];

  // Multiplier operand select
  always_comb begin
    mul_a = 16'sd0;
    mul_b = 16'sd0;
    case (state)
      S_MUL0: begin
        mul_a = na;
        mul_b = (fn == FUNC_MUL) ? nb : db;
      end
      S_MUL1: begin
        mul_a = da;
        mul_b = nb;
      end
      S_MUL2: begin
        mul_a = da;
        mul_b = (fn == FUNC_DIV) ? nb : db;
      end
      default: begin
        mul_a = 16'sd0;
        mul_b = 16'sd0;
      end
    endcase
  end

  // Adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_ADD: begin
        alu_a   = {{2{p0[31]}}, p0};
        alu_b   = (fn == FUNC_ADD || fn == FUNC_SUB) ? {{2{p1[31]}}, p1} : '0;
        alu_sub = (fn == FUNC_SUB);
      end
      S_ABSN: begin
        alu_b   = {rn[32], rn};
        alu_sub = 1'b1;
      end
      S_ABSD: begin
        alu_b   = {{2{rd[31]}}, rd};
        alu_sub = 1'b1;
      end
      S_GCD: begin
        alu_a   = {2'b00, u};
        alu_b   = {2'b00, v};
        alu_sub = 1'b1;
      end
      S_DIVN, S_DIVD: begin
        alu_a   = {2'b00, div_trial_in};
        alu_b   = {2'b00, u};
        alu_sub = 1'b1;
      end
      S_NEGN: begin
        alu_b   = {2'b00, mag_n};
        alu_sub = 1'b1;
      end
      S_NEGD: begin
        alu_b   = {2'b00, q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output word once taken, unless S_DONE reloads it below.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            fn    <= func;
            na    <= num_a;
            da    <= den_a;
            nb    <= num_b;
            db    <= den_b;
            state <= S_MUL0;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: begin
          p0    <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1    <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          rd    <= mul_p;
          state <= S_ADD;
        end
        S_ADD: begin
          rn    <= alu_res[32:0];
          state <= S_CHK;
        end
        S_CHK: begin
          // Zero denominator flags an error; zero numerator reduces to 0/1.
          if (rd == 32'sd0) begin
            res_num <= '0;
            res_den <= '0;
            res_bad <= 1'b1;
            state   <= S_DONE;
          end else if (rn == 33'sd0) begin
            res_num <= '0;
            res_den <= 32'sd1;
            res_bad <= 1'b0;
            state   <= S_DONE;
          end else begin
            state <= S_ABSN;
          end
        end
        S_ABSN: begin
          sign_n <= rn[32];
          mag_n  <= rn[32] ? alu_res[31:0] : rn[31:0];
          state  <= S_ABSD;
        end
        S_ABSD: begin
          sign_d <= rd[31];
          mag_d  <= rd[31] ? alu_res[31:0] : rd;
          v      <= rd[31] ? alu_res[31:0] : rd;
          u      <= mag_n;
          state  <= S_GCD;
        end
        S_GCD: begin
          // Binary GCD, one step per cycle. Common factors of two come out
          // of the magnitudes along with u and v, leaving an odd divisor in u.
          if (!u[0] && !v[0]) begin
            u     <= {1'b0, u[31:1]};
            v     <= {1'b0, v[31:1]};
            mag_n <= {1'b0, mag_n[31:1]};
            mag_d <= {1'b0, mag_d[31:1]};
          end else if (!u[0]) begin
            u <= {1'b0, u[31:1]};
          end else if (!v[0]) begin
            v <= {1'b0, v[31:1]};
          end else if (alu_res == '0) begin
            q     <= mag_n;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (alu_res[WORD_W-1]) begin
            // Swap so the larger odd value is reduced next cycle.
            u <= v;
            v <= u;
          end else begin
            u <= alu_res[31:0];
          end
        end
        S_DIVN: begin
          if (cnt == 5'd31) begin
            mag_n <= {q[30:0], div_bit};
            q     <= mag_d;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVD;
          end else begin
            rem <= div_bit ? alu_res[31:0] : div_trial_in;
            cnt <= cnt + 5'd1;
            q   <= {q[30:0], div_bit};
          end
        end
        S_DIVD: begin
          rem <= div_bit ? alu_res[31:0] : div_trial_in;
          q   <= {q[30:0], div_bit};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_NEGN;
          end
        end
        S_NEGN: begin
          res_num <= sign_n ? alu_res[32:0] : {1'b0, mag_n};
          state   <= S_NEGD;
        end
        S_NEGD: begin
          res_den <= sign_d ? alu_res[31:0] : q;
          res_bad <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            num_out         <= res_num;
            den_out         <= res_den;
            bad_denominator <= res_bad;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
